// ===== rtl/core/gers_pkg.sv =====
// Shared types and constants for the edge-renormalized Gaussian smoother.
package gers_pkg;

  localparam int NUM_TAPS   = 7;
  localparam int RADIUS_W   = 3;
  localparam int WEIGHT_W   = 16;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  // Center tap is exactly 1.0 in Q1.16, one bit wider than a Q0.16 tap word.
  localparam logic [WEIGHT_W:0] CENTRE_WEIGHT = {1'b1, {WEIGHT_W{1'b0}}};

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 3'd3;
  localparam logic [WEIGHT_W-1:0] TAP_RESET [NUM_TAPS] = '{
    16'd57835, 16'd39750, 16'd21280, 16'd0, 16'd0, 16'd0, 16'd0
  };

  // Register indexes (byte address / 4).
  localparam logic [REG_IDX_W-1:0] REG_RADIUS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TAP_1  = 3'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DIV,
    ST_OUT
  } gers_state_e;

endpackage

// ===== rtl/core/gers_in_if.sv =====
// Input sample channel: valid/ready handshake with sample payload.
interface gers_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

// ===== rtl/core/gers_out_if.sv =====
// Result channel: valid/ready handshake with smoothed-value payload.
interface gers_out_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] smoothed;
  logic                          last_result;

  modport source (output valid, smoothed, last_result, input ready);
  modport sink   (input valid, smoothed, last_result, output ready);
endinterface

// ===== rtl/core/gaussian_edge_renorm_smoother_core.sv =====
// Top level of the edge-renormalized Gaussian smoother.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+----------------------------------
//   in_i     | in  | valid / ready  | sample (signed), last_sample
//   out_o    | out | valid / ready  | smoothed (signed), last_result
//   APB      | in  | psel / penable | paddr, pwdata, prdata, pready = 1
//
// Each result walks its 2r+1 taps through the history RAM one per cycle
// (shared multiply-accumulate), then a serial divider produces one quotient
// bit per cycle. A last beat emits up to r+1 results back to back. Reset
// clears control state and the sequence count; the history RAM is not
// cleared, since only entries written in the current sequence are used.
// A stalled result sits in the output register; a new beat is taken as soon
// as the engine returns to idle, so the result stall only holds the engine
// when the next result is ready to load.
module gaussian_edge_renorm_smoother_core #(
  parameter int MAX_RADIUS  = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  gers_in_if.sink                           in_i,
  gers_out_if.source                        out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gers_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [gers_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [gers_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  import gers_pkg::*;

  localparam int HIST_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int IDX_W      = $clog2(HIST_DEPTH);
  localparam int SEEN_W     = $clog2(HIST_DEPTH + 1);
  localparam int AGE_W      = SEEN_W + 1;
  localparam int RMAX       = (MAX_RADIUS < NUM_TAPS) ? MAX_RADIUS : NUM_TAPS;
  localparam int CNT_W      = $clog2(2 * RMAX + 1);
  localparam int MAG_W      = CNT_W + 1;
  localparam int WFULL_W    = WEIGHT_W + 1;
  localparam int PROD_W     = SAMPLE_BITS + WFULL_W + 1;
  localparam int NUM_W      = PROD_W + SEEN_W;
  localparam int DEN_W      = WFULL_W + SEEN_W;
  localparam int DVD_W      = NUM_W + 1;
  localparam int DVS_W      = DEN_W + 1;
  localparam int QB         = SAMPLE_BITS;

  localparam logic [QB-1:0] POS_MAX = {1'b0, {(QB-1){1'b1}}};
  localparam logic [QB-1:0] NEG_MAG = {1'b1, {(QB-1){1'b0}}};

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [RADIUS_W-1:0]  window_radius_q;
  logic [WEIGHT_W-1:0]  tap_q [NUM_TAPS];
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [REG_IDX_W-1:0] tap_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[REG_IDX_W+1:2];
  assign tap_sel = REG_IDX_W'(cfg_idx - REG_TAP_1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_radius_q <= RADIUS_RESET;
      for (int i = 0; i < NUM_TAPS; i++) begin
        tap_q[i] <= TAP_RESET[i];
      end
    end else if (cfg_we) begin
      if (cfg_idx == REG_RADIUS) begin
        window_radius_q <= pwdata[RADIUS_W-1:0];
      end else begin
        tap_q[tap_sel] <= pwdata[WEIGHT_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_idx == REG_RADIUS) begin
      prdata = APB_DATA_W'(window_radius_q);
    end else begin
      prdata = APB_DATA_W'(tap_q[tap_sel]);
    end
  end

  // Clamp the radius to what the history and the tap table hold.
  logic [RADIUS_W-1:0] r_eff;
  assign r_eff = (int'(window_radius_q) > RMAX) ? RADIUS_W'(RMAX) : window_radius_q;

  // ---------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------
  gers_state_e         state_q, state_d;
  logic [IDX_W-1:0]    wptr_q, wptr_d;     // slot of the newest sample
  logic [SEEN_W-1:0]   seen_q, seen_d;     // samples in this sequence, saturating
  logic                last_q, last_d;
  logic [RADIUS_W-1:0] r_q, r_d;           // radius latched at accept
  logic [RADIUS_W-1:0] c_q, c_d;           // age of the position being smoothed
  logic [CNT_W-1:0]    cnt_q, cnt_d;       // tap counter

  logic                in_ready;
  logic                ram_we;
  logic                issue;
  logic                acc_clr;
  logic                div_start;
  logic                div_done;
  logic                out_load;

  logic [IDX_W-1:0]    wptr_next;
  logic [SEEN_W-1:0]   seen_inc;
  logic [SEEN_W-1:0]   seen_top;
  logic [RADIUS_W-1:0] c_first_last;
  logic [CNT_W-1:0]    cnt_end;

  logic                s1_v_q;
  logic                p2_v_q;
  logic                out_valid_q;
  logic                out_last_d;

  assign wptr_next    = (wptr_q == IDX_W'(HIST_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
  assign seen_inc     = (seen_q < SEEN_W'(HIST_DEPTH)) ? seen_q + 1'b1 : seen_q;
  assign seen_top     = seen_inc - 1'b1;
  assign c_first_last = (int'(seen_top) > int'(r_eff)) ? r_eff : RADIUS_W'(seen_top);
  assign cnt_end      = CNT_W'({r_q, 1'b0});
  assign out_last_d   = last_q && (c_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wptr_q  <= '0;
      seen_q  <= '0;
      last_q  <= 1'b0;
      r_q     <= '0;
      c_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      wptr_q  <= wptr_d;
      seen_q  <= seen_d;
      last_q  <= last_d;
      r_q     <= r_d;
      c_q     <= c_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    wptr_d    = wptr_q;
    seen_d    = seen_q;
    last_d    = last_q;
    r_d       = r_q;
    c_d       = c_q;
    cnt_d     = cnt_q;
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    issue     = 1'b0;
    acc_clr   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          // Store the beat, then decide whether a result is due.
          ram_we  = 1'b1;
          wptr_d  = wptr_next;
          seen_d  = seen_inc;
          last_d  = in_i.last_sample;
          r_d     = r_eff;
          cnt_d   = '0;
          acc_clr = 1'b1;
          if (in_i.last_sample) begin
            c_d     = c_first_last;
            state_d = ST_MAC;
          end else if (int'(seen_inc) > int'(r_eff)) begin
            c_d     = r_eff;
            state_d = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        issue = 1'b1;
        if (cnt_q == cnt_end) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!s1_v_q && !p2_v_q) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          if (last_q && (c_q != '0)) begin
            // Flush: advance to the next younger position.
            c_d     = c_q - 1'b1;
            cnt_d   = '0;
            acc_clr = 1'b1;
            state_d = ST_MAC;
          end else begin
            if (last_q) begin
              seen_d = '0;
            end
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_i.ready = in_ready;

  // ---------------------------------------------------------------------
  // Tap issue: age of the tapped sample, its weight and how it counts
  // ---------------------------------------------------------------------
  logic signed [AGE_W-1:0] age;
  logic signed [AGE_W-1:0] seen_s;
  logic [MAG_W-1:0]        cnt_x;
  logic [MAG_W-1:0]        r_x;
  logic [MAG_W-1:0]        mag_full;
  logic [RADIUS_W-1:0]     mag;
  logic [WFULL_W-1:0]      tap_w;
  logic                    age_neg;
  logic                    tap_inside;
  logic                    tap_pad;
  logic [IDX_W-1:0]        age_idx;
  logic [IDX_W:0]          addr_diff;
  logic [IDX_W-1:0]        raddr;

  assign age = $signed(AGE_W'(c_q)) + $signed(AGE_W'(r_q)) - $signed(AGE_W'(cnt_q));
  assign seen_s  = $signed({1'b0, seen_q});
  assign age_neg = age[AGE_W-1];

  assign cnt_x    = MAG_W'(cnt_q);
  assign r_x      = MAG_W'(r_q);
  assign mag_full = (cnt_x >= r_x) ? cnt_x - r_x : r_x - cnt_x;
  assign mag      = RADIUS_W'(mag_full);
  assign tap_w    = (mag == '0) ? CENTRE_WEIGHT : {1'b0, tap_q[RADIUS_W'(mag - 1'b1)]};

  // A real sample adds value and weight; the leading pad (one past the
  // oldest sample) and, on a flush, the trailing pad add weight only.
  assign tap_inside = !age_neg && (age < seen_s);
  assign tap_pad    = (!age_neg && (age == seen_s)) ||
                      (last_q && (age == {AGE_W{1'b1}}));

  assign age_idx   = age[IDX_W-1:0];
  assign addr_diff = {1'b0, wptr_q} - {1'b0, age_idx};
  assign raddr     = addr_diff[IDX_W] ? IDX_W'(addr_diff + (IDX_W+1)'(HIST_DEPTH))
                                      : addr_diff[IDX_W-1:0];

  logic [SAMPLE_BITS-1:0] hist_rdata;

  gers_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wptr_next),
    .wdata_i (in_i.sample),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (hist_rdata)
  );

  // ---------------------------------------------------------------------
  // Multiply-accumulate pipeline: issue -> RAM/multiply -> accumulate
  // ---------------------------------------------------------------------
  logic                     s1_num_q;
  logic                     s1_den_q;
  logic [WFULL_W-1:0]       s1_w_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] p2_prod_q;
  logic [WFULL_W-1:0]       p2_den_w_q;
  logic signed [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]         den_q;

  assign prod = $signed({1'b0, s1_w_q}) * $signed(hist_rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      p2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_num_q   <= tap_inside;
    s1_den_q   <= tap_inside || tap_pad;
    s1_w_q     <= tap_w;
    p2_prod_q  <= s1_num_q ? prod : '0;
    p2_den_w_q <= s1_den_q ? s1_w_q : '0;
    if (acc_clr) begin
      num_q <= '0;
      den_q <= '0;
    end else if (p2_v_q) begin
      num_q <= num_q + NUM_W'(p2_prod_q);
      den_q <= den_q + DEN_W'(p2_den_w_q);
    end
  end

  // ---------------------------------------------------------------------
  // Rounded division: q = (2|num| + den) / (2 den), ties away from zero
  // ---------------------------------------------------------------------
  logic             num_neg;
  logic [NUM_W-1:0] num_mag;
  logic [DVD_W-1:0] dividend;
  logic [DVS_W-1:0] divisor;
  logic [QB-1:0]    quotient;

  assign num_neg  = num_q[NUM_W-1];
  assign num_mag  = num_neg ? NUM_W'(~num_q + 1'b1) : NUM_W'(num_q);
  assign dividend = {num_mag, 1'b0} + DVD_W'(den_q);
  assign divisor  = {den_q, 1'b0};

  gers_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W),
    .QB    (QB)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Apply the sign and saturate to the sample range.
  logic [QB-1:0] result;

  always_comb begin
    if (num_neg) begin
      result = (quotient > NEG_MAG) ? NEG_MAG : QB'(~quotient + 1'b1);
    end else begin
      result = (quotient > POS_MAX) ? POS_MAX : quotient;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] out_smoothed_q;
  logic                   out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_smoothed_q <= result;
      out_last_q     <= out_last_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.smoothed    = $signed(out_smoothed_q);
  assign out_o.last_result = out_last_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV || state_q == ST_OUT) |-> (!s1_v_q && !p2_v_q))
    else $error("accumulate pipeline busy during divide or output");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> (seen_q == '0 && state_q == ST_IDLE))
    else $error("final result did not close the sequence");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (cnt_q <= cnt_end && c_q <= r_q))
    else $error("tap counter or position out of window");

endmodule

// ===== rtl/core/gers_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gers_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 15
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/gers_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module gers_div #(
  parameter int DVD_W = 39,
  parameter int DVS_W = 22,
  parameter int QB    = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [QB-1:0]    quotient_o
);

  localparam int CNT_W = $clog2(QB);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] rem_q;
  logic [DVD_W-1:0] dsh_q;
  logic [QB-1:0]    quo_q;
  logic             fits;

  assign fits = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QB - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Align the divisor under the top quotient bit, then walk it down.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      dsh_q <= DVD_W'(divisor_i) << (QB - 1);
      quo_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[QB-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== bench/tb_gaussian_edge_renorm_smoother_core.sv =====
// Self-checking testbench for the edge-renormalized Gaussian smoother core.
`timescale 1ns / 100ps

module tb_gaussian_edge_renorm_smoother_core;
  import gers_pkg::*;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_RADIUS  = 7;
  localparam int HIST_DEPTH  = 2 * MAX_RADIUS + 1;
  // A last beat can emit up to r+1 results, each a full tap walk and divide.
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic                          last_result;
  } smoothed_beat_t;

  logic clk;
  logic rst_ni;

  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [APB_ADDR_W-1:0]   paddr;
  logic [APB_DATA_W-1:0]   pwdata;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  gers_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  gers_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  gaussian_edge_renorm_smoother_core #(
    .MAX_RADIUS (MAX_RADIUS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow copy of the register file, updated when a write lands.
  logic [RADIUS_W-1:0] cfg_radius;
  logic [WEIGHT_W-1:0] cfg_tap [1:NUM_TAPS];

  // Shadow copy of the sequence state: newest sample at index 0.
  logic signed [SAMPLE_BITS-1:0] hist [HIST_DEPTH];
  int                            hist_count;

  smoothed_beat_t smoothed_expected_q [$];

  int err_count;
  bit tx_idle_en;
  bit rx_idle_en;
  int rx_hold_cycles;

  // Clock: 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  //--------------------------------------------------------------------------
  // Prediction
  //--------------------------------------------------------------------------

  // Weight of a tap at distance mag from the center, as an exact integer.
  function automatic longint unsigned tap_weight_at(int mag);
    if (mag == 0) return longint'(CENTRE_WEIGHT);
    if (mag > NUM_TAPS) return 0;
    return longint'(cfg_tap[mag]);
  endfunction

  // Renormalized weighted mean for the position of age c (0 = newest).
  // Taps that fall on a pad add weight only; taps beyond the pads drop out.
  function automatic logic signed [SAMPLE_BITS-1:0] weighted_mean(int c, int r, bit lst);
    longint          num;
    longint unsigned den;
    longint unsigned w;
    longint unsigned mag;
    longint unsigned quo;
    longint          res;
    int              age;
    int              d;
    num = 0;
    den = 0;
    for (d = -r; d <= r; d++) begin
      age = c - d;
      w   = tap_weight_at(d < 0 ? -d : d);
      if (age < 0) begin
        // Trailing pad exists only once the last sample has come in.
        if (age == -1 && lst) den += w;
      end else if (age == hist_count) begin
        den += w;
      end else if (age < hist_count && age < HIST_DEPTH) begin
        num += longint'(w) * longint'(hist[age]);
        den += w;
      end
    end
    // Round half away from zero on the magnitude.
    mag = (num < 0) ? longint'(-num) : longint'(num);
    quo = (mag * 2 + den) / (den * 2);
    res = (num < 0) ? -longint'(quo) : longint'(quo);
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[SAMPLE_BITS-1:0];
  endfunction

  // Append one expected result beat to the scoreboard queue.
  function automatic void enqueue_smoothed(smoothed_beat_t b);
    smoothed_expected_q = {smoothed_expected_q, b};
  endfunction

  // Advance the shadow sequence by one accepted beat and queue its results.
  function automatic void predict_smoothed(logic signed [SAMPLE_BITS-1:0] smp, bit lst);
    int             r;
    int             top;
    int             c;
    int             i;
    smoothed_beat_t b;
    r = int'(cfg_radius);
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    for (i = HIST_DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = smp;
    if (hist_count < HIST_DEPTH) hist_count++;
    if (!lst) begin
      if (hist_count > r) begin
        b.smoothed    = weighted_mean(r, r, 1'b0);
        b.last_result = 1'b0;
        enqueue_smoothed(b);
      end
    end else begin
      // Flush every position not yet given, oldest first.
      top = hist_count - 1;
      if (top > r) top = r;
      for (c = top; c >= 0; c--) begin
        b.smoothed    = weighted_mean(c, r, 1'b1);
        b.last_result = (c == 0);
        enqueue_smoothed(b);
      end
      hist_count = 0;
    end
  endfunction

  //--------------------------------------------------------------------------
  // Register port
  //--------------------------------------------------------------------------

  // Setup cycle, then access cycle; the write lands on the access edge.
  task automatic apb_write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_RADIUS) cfg_radius = value[RADIUS_W-1:0];
    else cfg_tap[int'(idx - REG_TAP_1) + 1] = value[WEIGHT_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_tap(input int k, input logic [WEIGHT_W-1:0] value);
    apb_write_reg(REG_TAP_1 + REG_IDX_W'(k - 1), {16'd0, value});
  endtask

  task automatic write_all_taps(input logic [WEIGHT_W-1:0] value);
    for (int k = 1; k <= NUM_TAPS; k++) write_tap(k, value);
  endtask

  //--------------------------------------------------------------------------
  // Sample channel
  //--------------------------------------------------------------------------

  // Offer one beat, after a random gap if tx_idle_en is set; hold it until the core takes it.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input bit lst);
    int gap;
    gap = tx_idle_en ? $urandom_range(11, 0) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= smp;
    in_ch.last_sample <= lst;
    do @(posedge clk); while (!in_ch.ready);
    predict_smoothed(smp, lst);
  endtask

  // Drop valid, wait for every queued result, then let the engine settle.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (smoothed_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(7, 0))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(5, 0))
      0:       return 16'd0;
      1:       return 16'hffff;
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  //--------------------------------------------------------------------------
  // Result channel: receiver and checker
  //--------------------------------------------------------------------------

  // Draw a stall per result when rx_idle_en is set; honor a requested long hold-off first.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_cycles > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end
      gap = rx_idle_en ? $urandom_range(11, 0) : 0;
      if (gap > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    smoothed_beat_t exp_beat;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (smoothed_expected_q.size() == 0) begin
        $error("unexpected result beat: smoothed %0d, last_result %0b",
               out_ch.smoothed, out_ch.last_result);
        err_count++;
      end else begin
        exp_beat = smoothed_expected_q.pop_front();
        if (out_ch.smoothed !== exp_beat.smoothed) begin
          $error("smoothed mismatch: expected %0d, actual %0d",
                 exp_beat.smoothed, out_ch.smoothed);
          err_count++;
        end
        if (out_ch.last_result !== exp_beat.last_result) begin
          $error("last_result mismatch: expected %0b, actual %0b",
                 exp_beat.last_result, out_ch.last_result);
          err_count++;
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // Tests
  //--------------------------------------------------------------------------

  // Reset radius and taps, with the sample extremes.
  task automatic test_reset_defaults();
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sh7fff, 1'b1);
  endtask

  // Radius zero: every result equals its own sample.
  task automatic test_passthrough();
    wait_drained();
    apb_write_reg(REG_RADIUS, 32'd0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sh7fff, 1'b1);
  endtask

  // Widest kernel with every tap at full scale.
  task automatic test_max_radius_full_taps();
    wait_drained();
    apb_write_reg(REG_RADIUS, 32'd7);
    write_all_taps(16'hffff);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd255, 1'b0);
    send_sample(-16'sd256, 1'b1);
  endtask

  // Short sequences flush at once; half-weight pads give exact ties.
  task automatic test_short_sequence_ties();
    wait_drained();
    apb_write_reg(REG_RADIUS, 32'd1);
    write_tap(1, 16'd32768);
    send_sample(16'sd1, 1'b1);
    send_sample(-16'sd1, 1'b1);
    send_sample(-16'sd3, 1'b1);
    wait_drained();
    apb_write_reg(REG_RADIUS, 32'd5);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sd3, 1'b1);
  endtask

  // All side taps zero: only the center counts.
  task automatic test_zero_weights();
    wait_drained();
    apb_write_reg(REG_RADIUS, 32'd4);
    write_all_taps(16'd0);
    send_sample(16'sh1234, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sd5, 1'b1);
  endtask

  // Widen the radius inside an open sequence; positions repeat, no fault.
  // The pause also has the sender wait until every result has come.
  task automatic test_radius_change_mid_sequence();
    wait_drained();
    apb_write_reg(REG_RADIUS, 32'd2);
    write_tap(1, 16'd40000);
    write_tap(2, 16'd9000);
    send_sample(16'sd10, 1'b0);
    send_sample(16'sd20, 1'b0);
    send_sample(16'sd30, 1'b0);
    wait_drained();
    apb_write_reg(REG_RADIUS, 32'd6);
    send_sample(16'sd40, 1'b1);
  endtask

  // Hold the result side off for a long stretch while beats keep coming,
  // so the core fills up and stalls its input.
  task automatic test_result_backpressure();
    wait_drained();
    apb_write_reg(REG_RADIUS, 32'd7);
    for (int k = 1; k <= NUM_TAPS; k++) write_tap(k, rand_weight());
    tx_idle_en     = 1'b0;
    rx_hold_cycles = 600;
    for (int i = 0; i < 24; i++) send_sample(rand_sample(), i == 23);
    wait_drained();
    tx_idle_en = 1'b1;
  endtask

  // One random setting, then whole sequences with random content.
  task automatic test_random_phase(input int items, input bit idle);
    int sent;
    int len;
    int pause_at;
    wait_drained();
    apb_write_reg(REG_RADIUS, 32'($urandom_range(7, 0)));
    for (int k = 1; k <= NUM_TAPS; k++) write_tap(k, rand_weight());
    tx_idle_en = idle;
    rx_idle_en = idle;
    sent = 0;
    while (sent < items) begin
      // Mostly short sequences, some long enough to fill the history.
      len = ($urandom_range(5, 0) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
      pause_at = ($urandom_range(9, 0) == 0) ? $urandom_range(len - 1, 0) : -1;
      for (int i = 0; i < len; i++) begin
        if (i == pause_at && i > 0) wait_drained();
        send_sample(rand_sample(), i == len - 1);
        sent++;
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  //--------------------------------------------------------------------------
  // Sequencer
  //--------------------------------------------------------------------------

  initial begin
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.sample      = '0;
    in_ch.last_sample = 1'b0;
    err_count         = 0;
    tx_idle_en        = 1'b1;
    rx_idle_en        = 1'b1;
    rx_hold_cycles    = 0;
    cfg_radius        = RADIUS_RESET;
    for (int k = 1; k <= NUM_TAPS; k++) cfg_tap[k] = TAP_RESET[k-1];
    for (int i = 0; i < HIST_DEPTH; i++) hist[i] = '0;
    hist_count = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_passthrough();
    test_max_radius_full_taps();
    test_short_sequence_ties();
    test_zero_weights();
    test_radius_change_mid_sequence();
    test_result_backpressure();
    for (int p = 0; p < 7; p++) test_random_phase(30, p != 3);

    wait_drained();
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gers_pkg.sv
rtl/core/gers_in_if.sv
rtl/core/gers_out_if.sv
rtl/core/gers_ram.sv
rtl/core/gers_div.sv
rtl/core/gaussian_edge_renorm_smoother_core.sv
bench/tb_gaussian_edge_renorm_smoother_core.sv
